>>> sv/dpsg_pkg.sv
// Shared constants, types and codes for the dual sound chip register write unit.
package dpsg_pkg;

	localparam int NUM_CHIPS = 2;
	localparam int CHIP_W    = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
	localparam int NUM_TONES = 3;
	localparam int NUM_ATTEN = 4;
	localparam int PERIOD_W  = 10;
	localparam int VOL_W     = 4;
	localparam int NOISE_W   = 3;
	localparam int REG_W     = 3;

	localparam logic [1:0]       NOISE_CHANNEL = 2'd3;
	localparam logic [VOL_W-1:0] VOL_MAX       = 4'd15;

	typedef enum logic [1:0] {
		WK_TONE,
		WK_ATTEN,
		WK_NOISE
	} wr_kind_t;

	// Write command for one transaction, decoded from the byte and the latch.
	typedef struct packed {
		logic             set_latch;
		logic [REG_W-1:0] reg_num;
		wr_kind_t         kind;
		logic [1:0]       channel;
	} wr_cmd_t;

	// Mapped view of one chip after a write.
	typedef struct packed {
		logic [NUM_TONES-1:0][PERIOD_W-1:0] period;
		logic [NUM_TONES-1:0][VOL_W-1:0]    volume;
		logic [NOISE_W-1:0]                 noise;
	} chip_view_t;

endpackage

>>> sv/dual_psg_register_write_unit.sv
// Top level of the dual sound chip register write unit.
//
// Takes one byte per transaction, addressed to one of NUM_CHIPS sound chips by
// chip_select (taken modulo the bank size), and returns one result transaction
// carrying that chip's mapped view after the write: three tone periods, three
// volumes (15 minus attenuation) and the noise control bits. A byte with bit 7
// set latches the register number and writes the low bits; a byte with bit 7
// clear continues the register last latched on that chip (register 0 after
// reset). Each transaction passes through the input register, then through the
// decode and register update into the result register. One transaction is
// accepted every cycle for as long as results are taken; the per-chip register
// update sets that rate.
// All chip state clears to zero on reset, with no clearing pass.
module dual_psg_register_write_unit
	import dpsg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                chip_select,
	input  logic [7:0]          data_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                chip_id,
	output logic [PERIOD_W-1:0] tone_a_period,
	output logic [PERIOD_W-1:0] tone_b_period,
	output logic [PERIOD_W-1:0] tone_c_period,
	output logic [VOL_W-1:0]    volume_a,
	output logic [VOL_W-1:0]    volume_b,
	output logic [VOL_W-1:0]    volume_c,
	output logic [NOISE_W-1:0]  noise_control
);

	// Input register stage
	logic              valid_s1;
	logic [CHIP_W-1:0] chip_s1;
	logic [7:0]        byte_s1;

	// Result register
	logic              chip_id_q;
	chip_view_t        view_q;

	logic              advance;
	logic [REG_W-1:0]  cur_reg;
	wr_cmd_t           cmd;
	chip_view_t        view;

	// Stage 1 moves on when the result register is empty or being emptied.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			// chip index is chip_select modulo the bank size
			chip_s1 <= (NUM_CHIPS > 1) ? CHIP_W'(chip_select) : '0;
			byte_s1 <= data_byte;
		end
	end

	dpsg_decode u_decode (
		.data_byte (byte_s1),
		.cur_reg   (cur_reg),
		.cmd       (cmd)
	);

	// State is updated only when the transaction moves into the result register.
	dpsg_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (advance),
		.chip_idx  (chip_s1),
		.data_byte (byte_s1),
		.cmd       (cmd),
		.cur_reg   (cur_reg),
		.view      (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			chip_id_q <= chip_s1[0];
			view_q    <= view;
		end
	end

	assign chip_id       = chip_id_q;
	assign tone_a_period = view_q.period[0];
	assign tone_b_period = view_q.period[1];
	assign tone_c_period = view_q.period[2];
	assign volume_a      = view_q.volume[0];
	assign volume_b      = view_q.volume[1];
	assign volume_c      = view_q.volume[2];
	assign noise_control = view_q.noise;

	// Input stalls only when both stages hold a transaction and output is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("input stalled without a full, blocked pipeline");

	// A transaction leaving stage 1 always lands in the result register.
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced transaction lost");

	// The reported chip is the chip that was written.
	a_chip_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (chip_id == $past(chip_s1[0])))
		else $error("result reports the wrong chip");

endmodule

>>> sv/dpsg_decode.sv
// Byte decoder: latch or data byte to a register write command.
module dpsg_decode
	import dpsg_pkg::*;
(
	input  logic [7:0]       data_byte,
	input  logic [REG_W-1:0] cur_reg,
	output wr_cmd_t          cmd
);

	logic [REG_W-1:0] reg_num;

	assign reg_num = data_byte[7] ? data_byte[6:4] : cur_reg;

	always_comb begin
		cmd.set_latch = data_byte[7];
		cmd.reg_num   = reg_num;
		cmd.channel   = reg_num[2:1];
		if (reg_num[0]) begin
			cmd.kind = WK_ATTEN;
		end else if (reg_num[2:1] == NOISE_CHANNEL) begin
			cmd.kind = WK_NOISE;
		end else begin
			cmd.kind = WK_TONE;
		end
	end

endmodule

>>> sv/dpsg_regfile.sv
// Per-chip register state, write update and mapped view of the chip written.
module dpsg_regfile
	import dpsg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CHIP_W-1:0] chip_idx,
	input  logic [7:0]        data_byte,
	input  wr_cmd_t           cmd,
	output logic [REG_W-1:0]  cur_reg,
	output chip_view_t        view
);

	logic [NUM_CHIPS-1:0][REG_W-1:0]                     latch_q, latch_d;
	logic [NUM_CHIPS-1:0][NUM_TONES-1:0][PERIOD_W-1:0]   tone_q, tone_d;
	logic [NUM_CHIPS-1:0][NUM_ATTEN-1:0][VOL_W-1:0]      atten_q, atten_d;
	logic [NUM_CHIPS-1:0][NOISE_W-1:0]                   noise_q, noise_d;

	assign cur_reg = latch_q[chip_idx];

	always_comb begin
		latch_d = latch_q;
		tone_d  = tone_q;
		atten_d = atten_q;
		noise_d = noise_q;
		for (int c = 0; c < NUM_CHIPS; c++) begin
			if (wr_en && (chip_idx == CHIP_W'(c))) begin
				if (cmd.set_latch) begin
					latch_d[c] = cmd.reg_num;
				end
				case (cmd.kind)
					WK_ATTEN: atten_d[c][cmd.channel] = data_byte[3:0];
					WK_NOISE: noise_d[c] = data_byte[2:0];
					WK_TONE: begin
						if (cmd.set_latch) begin
							tone_d[c][cmd.channel[0 +: 2]] =
								{tone_q[c][cmd.channel][9:4], data_byte[3:0]};
						end else begin
							tone_d[c][cmd.channel] =
								{data_byte[5:0], tone_q[c][cmd.channel][3:0]};
						end
					end
					default: ;
				endcase
			end
		end
	end

	// View of the chip written, as it stands after this write.
	always_comb begin
		for (int t = 0; t < NUM_TONES; t++) begin
			view.period[t] = tone_d[chip_idx][t];
			view.volume[t] = VOL_MAX - atten_d[chip_idx][t];
		end
		view.noise = noise_d[chip_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
			tone_q  <= '0;
			atten_q <= '0;
			noise_q <= '0;
		end else begin
			latch_q <= latch_d;
			tone_q  <= tone_d;
			atten_q <= atten_d;
			noise_q <= noise_d;
		end
	end

endmodule

>>> dv/dpsg_view_checker.sv
// Register view predictor and result comparator for the dual sound chip register write unit.
module dpsg_view_checker
	import dpsg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                chip_select,
	input  logic [7:0]          data_byte,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                chip_id,
	input  logic [PERIOD_W-1:0] tone_a_period,
	input  logic [PERIOD_W-1:0] tone_b_period,
	input  logic [PERIOD_W-1:0] tone_c_period,
	input  logic [VOL_W-1:0]    volume_a,
	input  logic [VOL_W-1:0]    volume_b,
	input  logic [VOL_W-1:0]    volume_c,
	input  logic [NOISE_W-1:0]  noise_control,
	output int                  mismatches,
	output int                  views_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       chip;
		chip_view_t view;
	} chip_report_t;

	// Shadow copy of every chip's registers
	logic [REG_W-1:0]    latched_reg [NUM_CHIPS];
	logic [PERIOD_W-1:0] tone_period [NUM_CHIPS][NUM_TONES];
	logic [VOL_W-1:0]    attenuation [NUM_CHIPS][NUM_ATTEN];
	logic [NOISE_W-1:0]  noise_bits  [NUM_CHIPS];

	chip_report_t expected_views [$];

	// Applies one byte write to the shadow registers, returns the chip's view after it
	function automatic chip_report_t apply_write(input logic cs, input logic [7:0] wr_byte);
		int unsigned      c;
		logic [REG_W-1:0] r;
		logic [1:0]       ch;
		chip_report_t     rep;
		c = int'(cs) % NUM_CHIPS;
		if (wr_byte[7])
			latched_reg[c] = wr_byte[6:4];
		r  = latched_reg[c];
		ch = r[2:1];
		if (r[0]) begin
			attenuation[c][ch] = wr_byte[3:0];
		end else if (ch != NOISE_CHANNEL) begin
			if (wr_byte[7])
				tone_period[c][ch][3:0] = wr_byte[3:0];
			else
				tone_period[c][ch][9:4] = wr_byte[5:0];
		end else begin
			noise_bits[c] = wr_byte[2:0];
		end
		rep.chip = c[0];
		for (int t = 0; t < NUM_TONES; t++) begin
			rep.view.period[t] = tone_period[c][t];
			rep.view.volume[t] = VOL_MAX - attenuation[c][t];
		end
		rep.view.noise = noise_bits[c];
		return rep;
	endfunction

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		chip_report_t head;
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHIPS; i++) begin
				latched_reg[i] = '0;
				noise_bits[i]  = '0;
				for (int t = 0; t < NUM_TONES; t++)
					tone_period[i][t] = '0;
				for (int a = 0; a < NUM_ATTEN; a++)
					attenuation[i][a] = '0;
			end
			expected_views.delete();
		end else begin
			if (in_valid && in_ready)
				expected_views.push_back(apply_write(chip_select, data_byte));
			if (out_valid && out_ready) begin
				if (expected_views.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result transaction, expected none, actual chip %0d",
						$time, chip_id);
				end else begin
					head = expected_views.pop_front();
					check_field("chip_id", 16'(head.chip), 16'(chip_id));
					check_field("tone_a_period", 16'(head.view.period[0]), 16'(tone_a_period));
					check_field("tone_b_period", 16'(head.view.period[1]), 16'(tone_b_period));
					check_field("tone_c_period", 16'(head.view.period[2]), 16'(tone_c_period));
					check_field("volume_a", 16'(head.view.volume[0]), 16'(volume_a));
					check_field("volume_b", 16'(head.view.volume[1]), 16'(volume_b));
					check_field("volume_c", 16'(head.view.volume[2]), 16'(volume_c));
					check_field("noise_control", 16'(head.view.noise), 16'(noise_control));
				end
			end
		end
		views_pending <= expected_views.size();
	end

endmodule

>>> dv/tb_dual_psg_register_write_unit.sv
// Top of the testbench for the dual sound chip register write unit: stimulus and verdict.
module tb_dual_psg_register_write_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// Register numbers as carried in bits 6..4 of a latch byte
	localparam logic [2:0] REG_TONE_A    = 3'd0;
	localparam logic [2:0] REG_ATT_A     = 3'd1;
	localparam logic [2:0] REG_TONE_B    = 3'd2;
	localparam logic [2:0] REG_ATT_B     = 3'd3;
	localparam logic [2:0] REG_TONE_C    = 3'd4;
	localparam logic [2:0] REG_ATT_C     = 3'd5;
	localparam logic [2:0] REG_NOISE     = 3'd6;
	localparam logic [2:0] REG_ATT_NOISE = 3'd7;

	localparam int LONG_HOLD    = 80;        // cycles the sink stalls to back the unit up
	localparam int RUN_LIMIT_NS = 1_000_000; // far beyond the slowest legal run

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic                         chip_select;
	logic [7:0]                   data_byte;
	logic                         out_valid;
	logic                         out_ready;
	logic                         chip_id;
	logic [dpsg_pkg::PERIOD_W-1:0] tone_a_period;
	logic [dpsg_pkg::PERIOD_W-1:0] tone_b_period;
	logic [dpsg_pkg::PERIOD_W-1:0] tone_c_period;
	logic [dpsg_pkg::VOL_W-1:0]    volume_a;
	logic [dpsg_pkg::VOL_W-1:0]    volume_b;
	logic [dpsg_pkg::VOL_W-1:0]    volume_c;
	logic [dpsg_pkg::NOISE_W-1:0]  noise_control;

	int   mismatches;
	int   views_pending;
	// Toggled by the stimulus to ask the sink for one long hold-off
	logic hold_req;

	dual_psg_register_write_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.chip_select   (chip_select),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.chip_id       (chip_id),
		.tone_a_period (tone_a_period),
		.tone_b_period (tone_b_period),
		.tone_c_period (tone_c_period),
		.volume_a      (volume_a),
		.volume_b      (volume_b),
		.volume_c      (volume_c),
		.noise_control (noise_control)
	);

	// Watches both channels, predicts each chip view and counts mismatches
	dpsg_view_checker u_view_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.chip_select   (chip_select),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.chip_id       (chip_id),
		.tone_a_period (tone_a_period),
		.tone_b_period (tone_b_period),
		.tone_c_period (tone_c_period),
		.volume_a      (volume_a),
		.volume_b      (volume_b),
		.volume_c      (volume_c),
		.noise_control (noise_control),
		.mismatches    (mismatches),
		.views_pending (views_pending)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Idle length: mostly none or short, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		else if (pick < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] latch_byte(input logic [2:0] reg_num, input logic [3:0] low);
		return {1'b1, reg_num, low};
	endfunction

	// Offers one byte transaction and holds it until taken; optional idle gap afterwards.
	// Called just after a rising edge, returns just after one.
	task automatic send_item(input logic cs, input logic [7:0] wr_byte, input bit with_gaps);
		int unsigned gap;
		chip_select <= cs;
		data_byte   <= wr_byte;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		gap = with_gaps ? idle_len() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mostly a latch byte followed by up to three data bytes to the same chip, random content;
	// one time in ten a stray byte to either chip, which also breaks up sequences.
	task automatic send_random_burst(input bit with_gaps, inout int sent);
		logic        cs;
		logic [2:0]  reg_num;
		int unsigned n_data;
		if ($urandom_range(0, 9) == 0) begin
			send_item(1'($urandom_range(0, 1)), 8'($urandom), with_gaps);
			sent++;
		end else begin
			cs      = 1'($urandom_range(0, 1));
			reg_num = 3'($urandom_range(0, 7));
			send_item(cs, latch_byte(reg_num, 4'($urandom)), with_gaps);
			sent++;
			n_data = $urandom_range(0, 3);
			repeat (n_data) begin
				send_item(cs, {1'b0, 7'($urandom)}, with_gaps);
				sent++;
			end
		end
	endtask

	// Sender pause: drop valid and wait for every outstanding view to come back.
	// The pending count is read on the falling edge, clear of the update at the rising one.
	task automatic wait_for_views();
		in_valid <= 1'b0;
		@(negedge clk);
		while (views_pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Sink: random ready with stretches of no back-pressure, plus one long hold on request
	initial begin : sink
		int unsigned stall_left;
		int unsigned run_left;
		logic        hold_seen;
		out_ready  = 1'b0;
		stall_left = 0;
		run_left   = 0;
		hold_seen  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req !== hold_seen) begin
				hold_seen  = hold_req;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (run_left > 0) begin
				out_ready <= 1'b1;
				run_left--;
			end else begin
				stall_left = idle_len();
				run_left   = $urandom_range(1, 24);
				if (stall_left > 0) begin
					out_ready <= 1'b0;
					stall_left--;
				end else begin
					out_ready <= 1'b1;
					run_left--;
				end
			end
		end
	end

	initial begin : stimulus
		int sent;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		chip_select = 1'b0;
		data_byte   = '0;
		hold_req    = 1'b0;
		sent        = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Data bytes before any latch continue register 0: high bits of tone A
		send_item(1'b0, 8'h3F, 1'b1);
		send_item(1'b1, 8'h00, 1'b1);
		// Every register of chip 0, latch and data forms, field extremes
		send_item(1'b0, latch_byte(REG_TONE_A, 4'hF), 1'b1);
		send_item(1'b0, latch_byte(REG_ATT_A, 4'hF), 1'b1);  // volume 0
		send_item(1'b0, 8'h40, 1'b1);                         // data byte on attenuation
		send_item(1'b0, latch_byte(REG_TONE_B, 4'h5), 1'b1);
		send_item(1'b0, 8'h2A, 1'b1);
		send_item(1'b0, latch_byte(REG_ATT_B, 4'h0), 1'b1);  // volume 15
		send_item(1'b0, latch_byte(REG_TONE_C, 4'hF), 1'b1);
		send_item(1'b0, 8'h7F, 1'b1);                         // bit 6 must be dropped
		send_item(1'b0, latch_byte(REG_ATT_C, 4'h7), 1'b1);
		send_item(1'b0, latch_byte(REG_NOISE, 4'hF), 1'b1);  // only three bits kept
		send_item(1'b0, 8'h05, 1'b1);                         // data byte on noise control
		// Noise attenuation is stored but not visible in the view
		send_item(1'b0, latch_byte(REG_ATT_NOISE, 4'hF), 1'b1);
		send_item(1'b0, 8'h00, 1'b1);
		// Chip 1, interleaved with chip 0 so the latches stay apart
		send_item(1'b1, latch_byte(REG_TONE_A, 4'h0), 1'b1);
		send_item(1'b1, 8'h7F, 1'b1);
		send_item(1'b0, 8'h0F, 1'b1);
		send_item(1'b1, latch_byte(REG_ATT_NOISE, 4'hF), 1'b1);
		send_item(1'b1, latch_byte(REG_NOISE, 4'h0), 1'b1);
		send_item(1'b1, 8'h78, 1'b1);
		send_item(1'b1, latch_byte(REG_TONE_C, 4'hA), 1'b1);
		send_item(1'b1, 8'h15, 1'b1);
		send_item(1'b0, latch_byte(REG_TONE_A, 4'h0), 1'b1);
		send_item(1'b0, 8'h00, 1'b1);
		wait_for_views();

		// Long sink hold-off while bytes keep coming back to back: the unit fills and stalls
		hold_req <= ~hold_req;
		while (sent < 40)
			send_random_burst(1'b0, sent);
		while (sent < 180)
			send_random_burst(1'b1, sent);
		wait_for_views();
		while (sent < 280)
			send_random_burst(1'b0, sent);
		while (sent < 400)
			send_random_burst(1'b1, sent);

		// Drain, then wait for any stray result transaction to show up
		wait_for_views();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS * 1ns);
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> dual_psg_register_write_unit.f
sv/dpsg_pkg.sv
sv/dpsg_decode.sv
sv/dpsg_regfile.sv
sv/dual_psg_register_write_unit.sv
dv/dpsg_view_checker.sv
dv/tb_dual_psg_register_write_unit.sv
